// File: hw/rtl/atdq_pkg.sv
// Package for the affinity task dispatch queue.
// Holds the beat and entry types and the operation, type and status codes.
// No dependencies.
`timescale 1ns / 1ps

package atdq_pkg;

    localparam logic [2:0] KIND_ENQ = 3'd0;
    localparam logic [2:0] KIND_REQ = 3'd1;
    localparam logic [2:0] KIND_CMP = 3'd2;
    localparam logic [2:0] KIND_REL = 3'd3;
    localparam logic [2:0] KIND_ACK = 3'd4;

    localparam logic [2:0] OP_ENQ  = 3'd0;
    localparam logic [2:0] OP_REQ  = 3'd1;
    localparam logic [2:0] OP_CMP  = 3'd2;
    localparam logic [2:0] OP_REL  = 3'd3;
    localparam logic [2:0] OP_ACK  = 3'd4;
    localparam logic [2:0] OP_NONE = 3'd5;

    localparam logic [1:0] TYPE_ORD  = 2'd0;
    localparam logic [1:0] TYPE_BAR  = 2'd1;
    localparam logic [1:0] TYPE_IDLE = 2'd2;
    localparam logic [1:0] TYPE_NOOP = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic REG_USE_AFF = 1'b0;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  worker;
        logic [15:0] task_tag;
        logic [1:0]  task_type;
        logic [4:0]  task_affinity;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_tag;
        logic [1:0]  out_type;
        logic        all_done;
        logic [4:0]  busy_count;
        logic [6:0]  queue_length;
    } t_result;

    typedef struct packed {
        logic [15:0] tag;
        logic [1:0]  etype;
        logic [4:0]  aff;
    } t_entry;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] worker;
        t_entry     entry;
    } t_cmd;

endpackage

// File: hw/rtl/atdq_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module atdq_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/atdq_front.sv
// Front end of the dispatch queue: accepts beats and classifies them into commands.
// Holds a two-entry command queue towards the back end. Depends on atdq_pkg.
`timescale 1ns / 1ps

module atdq_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  atdq_pkg::t_item  i_item,
    output logic             o_busy,
    output logic             o_cmd_valid,
    output atdq_pkg::t_cmd   o_cmd,
    input  logic             i_cmd_ready
);

    logic           r_v0, r_v1, n_v0, n_v1;
    atdq_pkg::t_cmd r_e0, r_e1, n_e0, n_e1;
    atdq_pkg::t_cmd w_cls;
    logic           w_push, w_pop;

    always_comb begin
        w_cls.worker      = i_item.worker;
        w_cls.entry.tag   = i_item.task_tag;
        w_cls.entry.etype = i_item.task_type;
        w_cls.entry.aff   = i_item.task_affinity;
        unique case (i_item.kind)
            atdq_pkg::KIND_ENQ: w_cls.op = atdq_pkg::OP_ENQ;
            atdq_pkg::KIND_REQ: w_cls.op = atdq_pkg::OP_REQ;
            atdq_pkg::KIND_CMP: w_cls.op = atdq_pkg::OP_CMP;
            atdq_pkg::KIND_REL: w_cls.op = atdq_pkg::OP_REL;
            atdq_pkg::KIND_ACK: w_cls.op = atdq_pkg::OP_ACK;
            default:            w_cls.op = atdq_pkg::OP_NONE;
        endcase
    end

    assign o_busy      = r_v1;
    assign w_push      = i_start & ~r_v1;
    assign w_pop       = r_v0 & i_cmd_ready;
    assign o_cmd_valid = r_v0;
    assign o_cmd       = r_e0;

    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_e0 = r_e0;
        n_e1 = r_e1;
        if (w_pop) begin
            n_v0 = r_v1;
            n_e0 = r_e1;
            n_v1 = 1'b0;
        end
        if (w_push) begin
            if (!n_v0) begin
                n_v0 = 1'b1;
                n_e0 = w_cls;
            end else begin
                n_v1 = 1'b1;
                n_e1 = w_cls;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
        r_e0 <= n_e0;
        r_e1 <= n_e1;
    end

endmodule

// File: hw/rtl/atdq_back.sv
// Back end of the dispatch queue: executes commands against the task store.
// Scans, compacts and dispenses entries held in atdq_ram. Depends on atdq_pkg.
`timescale 1ns / 1ps

module atdq_back #(
    parameter int QUEUE_DEPTH = 64,
    parameter int NUM_WORKERS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_use_aff,
    input  logic               i_cmd_valid,
    input  atdq_pkg::t_cmd     i_cmd,
    output logic               o_cmd_ready,
    output logic               o_res_valid,
    output atdq_pkg::t_result  o_res
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int BW = $clog2(NUM_WORKERS + 1);
    localparam int EW = $bits(atdq_pkg::t_entry);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SHR  = 3'd2;
    localparam logic [2:0] S_SHW  = 3'd3;
    localparam logic [2:0] S_TAKE = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [AW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_blocked, n_blocked;
    logic [3:0]             r_bwk, n_bwk;
    logic [BW-1:0]          r_busy, n_busy;
    logic [NUM_WORKERS-1:0] r_flags, n_flags;
    logic [3:0]             r_wk, n_wk;
    logic [AW:0]            r_ridx, n_ridx;
    logic                   r_cv, n_cv;
    logic [AW-1:0]          r_cidx, n_cidx;
    logic [AW-1:0]          r_j, n_j;
    atdq_pkg::t_entry       r_first, n_first;
    atdq_pkg::t_entry       r_sel, n_sel;
    logic                   r_res_valid, n_res_valid;
    atdq_pkg::t_result      r_res, n_res;

    logic                   w_we;
    logic [AW-1:0]          w_waddr, w_raddr;
    atdq_pkg::t_entry       w_wdata, w_rdata;
    logic [EW-1:0]          w_rdata_raw;
    logic                   w_flag_hit;
    logic [BW-1:0]          w_busy_inc;
    atdq_pkg::t_entry       w_first_sel;
    logic                   w_last;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW:0] idx);
        logic [AW:0] s;
        s = {1'b0, head} + idx;
        if (s >= (AW+1)'(QUEUE_DEPTH)) begin
            s = s - (AW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    atdq_ram #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata     = w_rdata_raw;
    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign w_busy_inc  = (r_busy < BW'(NUM_WORKERS)) ? r_busy + 1'b1 : r_busy;
    assign w_first_sel = (r_cidx == '0) ? w_rdata : r_first;
    assign w_last      = ((AW+1)'(r_cidx) + 1'b1) == (AW+1)'(r_count);

    always_comb begin
        w_flag_hit = 1'b0;
        for (int k = 0; k < NUM_WORKERS; k++) begin
            if (k == int'(i_cmd.worker) && r_flags[k]) begin
                w_flag_hit = 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_blocked   = r_blocked;
        n_bwk       = r_bwk;
        n_busy      = r_busy;
        n_flags     = r_flags;
        n_wk        = r_wk;
        n_ridx      = r_ridx;
        n_cv        = 1'b0;
        n_cidx      = r_cidx;
        n_j         = r_j;
        n_first     = r_first;
        n_sel       = r_sel;
        n_res_valid = 1'b0;
        n_res       = r_res;
        w_we        = 1'b0;
        w_waddr     = phys(r_head, (AW+1)'(r_count));
        w_wdata     = i_cmd.entry;
        w_raddr     = phys(r_head, r_ridx);

        n_res.status   = atdq_pkg::ST_DONE;
        n_res.out_tag  = '0;
        n_res.out_type = atdq_pkg::TYPE_NOOP;
        n_res.all_done = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_res_valid = 1'b1;
                    case (i_cmd.op)
                        atdq_pkg::OP_ENQ: begin
                            if (r_count >= CW'(QUEUE_DEPTH)) begin
                                n_res.status = atdq_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        atdq_pkg::OP_REQ: begin
                            if (r_blocked || (r_count == '0 && !w_flag_hit)) begin
                                n_res.status = atdq_pkg::ST_WAIT;
                            end else if (r_count == '0) begin
                                n_busy = w_busy_inc;
                            end else begin
                                n_res_valid = 1'b0;
                                n_wk        = i_cmd.worker;
                                n_ridx      = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        atdq_pkg::OP_CMP: begin
                            if (r_blocked && r_bwk == i_cmd.worker) begin
                                n_blocked = 1'b0;
                                n_bwk     = '0;
                            end
                            if (r_busy != '0) begin
                                n_busy = r_busy - 1'b1;
                            end
                            n_res.all_done = (n_busy == '0) && (r_count == '0);
                        end
                        atdq_pkg::OP_REL: begin
                            n_flags = '1;
                        end
                        atdq_pkg::OP_ACK: begin
                            for (int k = 0; k < NUM_WORKERS; k++) begin
                                if (k == int'(i_cmd.worker)) begin
                                    n_flags[k] = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                w_raddr = phys(r_head, r_ridx);
                n_ridx  = r_ridx + 1'b1;
                n_cv    = r_ridx < (AW+1)'(r_count);
                n_cidx  = r_ridx[AW-1:0];
                if (r_cv) begin
                    if (r_cidx == '0) begin
                        n_first = w_rdata;
                    end
                    if (!i_use_aff || w_rdata.etype == atdq_pkg::TYPE_BAR) begin
                        n_sel   = w_first_sel;
                        n_state = S_TAKE;
                    end else if (w_rdata.aff == {1'b0, r_wk}) begin
                        n_sel = w_rdata;
                        n_j   = r_cidx;
                        n_state = (r_cidx == '0) ? S_TAKE : S_SHR;
                    end else if (w_last) begin
                        n_sel   = w_first_sel;
                        n_state = S_TAKE;
                    end
                end
            end
            S_SHR: begin
                w_raddr = phys(r_head, (AW+1)'(r_j - 1'b1));
                n_state = S_SHW;
            end
            S_SHW: begin
                w_we    = 1'b1;
                w_waddr = phys(r_head, (AW+1)'(r_j));
                w_wdata = w_rdata;
                n_j     = r_j - 1'b1;
                n_state = (r_j == AW'(1)) ? S_TAKE : S_SHR;
            end
            S_TAKE: begin
                n_head  = phys(r_head, (AW+1)'(1));
                n_count = r_count - 1'b1;
                if (r_sel.etype == atdq_pkg::TYPE_BAR) begin
                    n_blocked = 1'b1;
                    n_bwk     = r_wk;
                end
                if (r_sel.etype != atdq_pkg::TYPE_IDLE) begin
                    n_busy = w_busy_inc;
                end
                n_res.out_type = r_sel.etype;
                n_res.out_tag  = (r_sel.etype == atdq_pkg::TYPE_NOOP) ? '0 : r_sel.tag;
                n_res_valid    = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res.busy_count   = 5'(n_busy);
        n_res.queue_length = 7'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_blocked   <= 1'b0;
            r_bwk       <= '0;
            r_busy      <= '0;
            r_flags     <= '0;
            r_cv        <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_blocked   <= n_blocked;
            r_bwk       <= n_bwk;
            r_busy      <= n_busy;
            r_flags     <= n_flags;
            r_cv        <= n_cv;
            r_res_valid <= n_res_valid;
        end
        r_wk    <= n_wk;
        r_ridx  <= n_ridx;
        r_cidx  <= n_cidx;
        r_j     <= n_j;
        r_first <= n_first;
        r_sel   <= n_sel;
        r_res   <= n_res;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < AW'(QUEUE_DEPTH - 1) || r_head == AW'(QUEUE_DEPTH - 1))
        else $error("head pointer out of range");

    a_no_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !r_res_valid)
        else $error("result issued while a request is in progress");

    a_blocked_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_cmd_valid && i_cmd.op == atdq_pkg::OP_REQ && r_blocked)
        |=> (r_res_valid && r_res.status == atdq_pkg::ST_WAIT))
        else $error("blocked request was not told to wait");
`endif

endmodule

// File: hw/rtl/affinity_task_dispatch_queue_core.sv
// Top level of the affinity task dispatch queue.
// Instantiates atdq_front and atdq_back and holds the APB configuration register.
// Depends on atdq_pkg.
`timescale 1ns / 1ps

// A command beat is taken on i_item at a clock edge where start is high and
// busy is low. Each beat gives exactly one result beat on o_res, marked by
// o_res_valid for one cycle; the receiver cannot hold it off.
// Enqueue, completion, release and acknowledge beats are answered with a
// registered result once the idle back end takes them from the front end.
// A request that dispenses a queued task scans the queue one entry per
// cycle, up to the first barrier, affinity match or the end of the queue,
// and then moves each entry ahead of the chosen one back by one slot, all
// through the single read and single write port of the task memory.
// The front end buffers two commands, so busy rises only while the back end
// is occupied with a long request.
// The use_affinity register sits at APB address 0. The user must write it only
// while the block is idle; the block does not enforce this. A synchronous reset
// empties the queue and clears blocking, busy count, release flags, use_affinity.
module affinity_task_dispatch_queue_core #(
    parameter int QUEUE_DEPTH = 64,
    parameter int NUM_WORKERS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  atdq_pkg::t_item    i_item,
    output logic               o_res_valid,
    output atdq_pkg::t_result  o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [0:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic           r_use_aff;
    logic           w_cmd_valid, w_cmd_ready;
    atdq_pkg::t_cmd w_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == atdq_pkg::REG_USE_AFF) ? {31'b0, r_use_aff} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_aff <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr == atdq_pkg::REG_USE_AFF) begin
            r_use_aff <= pwdata[0];
        end
    end

    atdq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .o_busy      (busy),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    atdq_back #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .NUM_WORKERS(NUM_WORKERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_use_aff   (r_use_aff),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
